@@ hw/rtl/mctt_pkg.sv @@
// ----------------------------------------------------------------------------
// mctt_pkg
// Shared types and constants for the multi-channel tick timer: command and
// result payloads, command codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mctt_pkg;

  localparam int unsigned CHANNELS = 16;

  // Channel index width and walk counter width (walk counter holds CHANNELS).
  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned IDX_W = $clog2(CHANNELS + 1);

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned MASK_W   = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 3'd0,
    MODE_SET   = 3'd1,
    MODE_START = 3'd2,
    MODE_STOP  = 3'd3,
    MODE_ALLOC = 3'd4
  } mode_e;

  typedef struct packed {
    mode_e                 mode;
    logic [CHAN_W-1:0]     channel;
    logic [PERIOD_W-1:0]   period;
    logic                  periodic;
  } req_t;

  typedef struct packed {
    logic [MASK_W-1:0]     fired_mask;
    logic                  granted;
    logic [CHAN_W-1:0]     granted_channel;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            capture;
    logic            exec;
    logic            rd_en;
    logic [CH_W-1:0] rd_addr;
    logic            proc_en;
    logic [CH_W-1:0] proc_addr;
    logic            mask_clr;
    logic            finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/mctt_ram.sv @@
// ----------------------------------------------------------------------------
// mctt_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module mctt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/mctt_ctrl.sv @@
// ----------------------------------------------------------------------------
// mctt_ctrl
// Controller: takes one request at a time, runs a tick as a walk over all
// channel entries and hands the result to the output register.
// ----------------------------------------------------------------------------
module mctt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                busy_o,
  input  mctt_pkg::dp_stat_t  stat_i,
  output mctt_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_FINISH
  } state_e;

  state_e                          state_q, state_d;
  logic [mctt_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic                            proc_vld_q, proc_vld_d;
  logic [mctt_pkg::CH_W-1:0]       proc_idx_q, proc_idx_d;
  logic                            busy_q;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    proc_vld_d = proc_vld_q;
    proc_idx_d = proc_idx_q;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.is_tick) begin
          // Read channel zero now; its data is processed in the first walk cycle.
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_addr  = '0;
          cmd_o.mask_clr = 1'b1;
          idx_d          = mctt_pkg::IDX_W'(1);
          proc_vld_d     = 1'b1;
          proc_idx_d     = '0;
          state_d        = ST_WALK;
        end else if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_WALK: begin
        cmd_o.proc_en   = proc_vld_q;
        cmd_o.proc_addr = proc_idx_q;
        if (idx_q < mctt_pkg::IDX_W'(mctt_pkg::CHANNELS)) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = idx_q[mctt_pkg::CH_W-1:0];
          proc_vld_d    = 1'b1;
          proc_idx_d    = idx_q[mctt_pkg::CH_W-1:0];
          idx_d         = idx_q + mctt_pkg::IDX_W'(1);
        end else begin
          proc_vld_d = 1'b0;
          state_d    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      proc_vld_q <= 1'b0;
      proc_idx_q <= '0;
      busy_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      proc_vld_q <= proc_vld_d;
      proc_idx_q <= proc_idx_d;
      busy_q     <= (state_d != ST_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

@@ hw/rtl/mctt_dp.sv @@
// ----------------------------------------------------------------------------
// mctt_dp
// Datapath: request register, channel flags, count and period memories,
// allocation counter, fired mask and the output register.
// ----------------------------------------------------------------------------
module mctt_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mctt_pkg::req_t      req_i,
  input  mctt_pkg::ctrl_cmd_t cmd_i,
  output mctt_pkg::dp_stat_t  stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mctt_pkg::rsp_t      out_data_o
);

  mctt_pkg::req_t                   cmd_q;
  logic [mctt_pkg::CHANNELS-1:0]    running_q;
  logic [mctt_pkg::CHANNELS-1:0]    armed_q;
  logic [mctt_pkg::CHANNELS-1:0]    repeats_q;
  logic [mctt_pkg::IDX_W-1:0]       next_free_q;
  logic [mctt_pkg::CHANNELS-1:0]    mask_q;
  logic                             out_valid_q, out_valid_d;
  mctt_pkg::rsp_t                   out_data_q, out_data_d;

  logic [mctt_pkg::CH_W-1:0]        chi;
  logic                             ch_ok;
  logic                             do_set, do_start, do_stop, do_alloc;
  logic                             grant;
  logic [mctt_pkg::COUNT_W-1:0]     count_rdata, count_inc;
  logic [mctt_pkg::PERIOD_W-1:0]    period_rdata;
  logic                             proc_live, fire;
  logic                             count_we;
  logic [mctt_pkg::CH_W-1:0]        count_waddr;
  logic [mctt_pkg::COUNT_W-1:0]     count_wdata;

  assign chi   = cmd_q.channel[mctt_pkg::CH_W-1:0];
  assign ch_ok = {1'b0, cmd_q.channel} < (mctt_pkg::CHAN_W + 1)'(mctt_pkg::CHANNELS);
  assign grant = next_free_q < mctt_pkg::IDX_W'(mctt_pkg::CHANNELS);

  always_comb begin
    do_set   = 1'b0;
    do_start = 1'b0;
    do_stop  = 1'b0;
    do_alloc = 1'b0;
    if (cmd_i.exec) begin
      unique case (cmd_q.mode)
        mctt_pkg::MODE_SET:   do_set   = ch_ok;
        mctt_pkg::MODE_START: do_start = ch_ok && armed_q[chi];
        mctt_pkg::MODE_STOP:  do_stop  = ch_ok && armed_q[chi];
        mctt_pkg::MODE_ALLOC: do_alloc = grant;
        default: ;
      endcase
    end
  end

  // Walk step: the channel's count and period arrive from the memories.
  assign proc_live = cmd_i.proc_en && running_q[cmd_i.proc_addr];
  assign count_inc = count_rdata + mctt_pkg::COUNT_W'(1);
  assign fire      = proc_live && (count_inc >= period_rdata);

  always_comb begin
    count_we    = 1'b0;
    count_waddr = chi;
    count_wdata = '0;
    if (do_set || do_start) begin
      count_we = 1'b1;
    end else if (proc_live) begin
      count_we    = 1'b1;
      count_waddr = cmd_i.proc_addr;
      count_wdata = fire ? '0 : count_inc;
    end
  end

  mctt_ram #(
    .WIDTH (mctt_pkg::COUNT_W),
    .DEPTH (mctt_pkg::CHANNELS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (count_we),
    .waddr_i (count_waddr),
    .wdata_i (count_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (count_rdata)
  );

  mctt_ram #(
    .WIDTH (mctt_pkg::PERIOD_W),
    .DEPTH (mctt_pkg::CHANNELS)
  ) u_period_ram (
    .clk_i   (clk_i),
    .we_i    (do_set),
    .waddr_i (chi),
    .wdata_i (cmd_q.period),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (period_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= req_i;
    end
    if (do_set) begin
      repeats_q[chi] <= cmd_q.periodic;
    end
    if (cmd_i.mask_clr) begin
      mask_q <= '0;
    end else if (fire) begin
      mask_q[cmd_i.proc_addr] <= 1'b1;
    end
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= '0;
      armed_q     <= '0;
      next_free_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (do_set || do_stop) begin
        running_q[chi] <= 1'b0;
      end else if (do_start) begin
        running_q[chi] <= 1'b1;
      end else if (fire && !repeats_q[cmd_i.proc_addr]) begin
        running_q[cmd_i.proc_addr] <= 1'b0;
      end
      if (do_set) begin
        armed_q[chi] <= 1'b1;
      end
      if (do_alloc) begin
        next_free_q <= next_free_q + mctt_pkg::IDX_W'(1);
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      if (do_alloc) begin
        out_data_d.granted         = 1'b1;
        out_data_d.granted_channel = mctt_pkg::CHAN_W'(next_free_q);
      end
    end else if (cmd_i.finish) begin
      out_valid_d           = 1'b1;
      out_data_d            = '0;
      out_data_d.fired_mask = mctt_pkg::MASK_W'(mask_q);
    end
  end

  assign stat_o.is_tick  = (cmd_q.mode == mctt_pkg::MODE_TICK);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;

endmodule

@@ hw/rtl/multi_channel_tick_timer.sv @@
// ----------------------------------------------------------------------------
// multi_channel_tick_timer
// Bank of tick-driven one-shot and periodic timer channels.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives exactly one result. With the
// output register free, set, start, stop, allocate and unused codes are
// executed from the request register and load the result register; a tick
// reads channel zero, walks the count and period memories one channel entry
// per cycle, reading the next entry while the previous one is updated, and
// then loads the fired mask.
// While the output register still holds a result that has not been taken,
// the new result waits in the controller until it is.
// The next request is taken as soon as the block is back in its idle state,
// even while the last result is still held in the output register.
module multi_channel_tick_timer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mctt_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mctt_pkg::rsp_t out_data_o
);

  mctt_pkg::ctrl_cmd_t cmd;
  mctt_pkg::dp_stat_t  stat;
  logic                busy;

  mctt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .busy_o     (busy),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mctt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = busy;

endmodule

@@ hw/rtl/mctt_checker.sv @@
// ----------------------------------------------------------------------------
// mctt_checker
// Port-level checks for the multi-channel tick timer, bound to the top level.
// ----------------------------------------------------------------------------
module mctt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input mctt_pkg::req_t in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input mctt_pkg::rsp_t out_data_o
);

  // A request is worked on alone, so the input side is busy right after it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while the previous one is in flight");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled request changed or dropped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // An allocation result never carries a fired mask.
  a_grant_no_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.granted |-> out_data_o.fired_mask == '0)
    else $error("granted result with nonzero fired mask");

  a_no_grant_zero_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.granted |-> out_data_o.granted_channel == '0)
    else $error("channel number reported without a grant");

endmodule

bind multi_channel_tick_timer mctt_checker u_mctt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
